>>> sv/unwind_record_framer_macros.svh
// ---------------------------------------------------------------------------
// unwind_record_framer_macros.svh
// Assertion macros shared by the framer checker.
// ---------------------------------------------------------------------------
`ifndef UNWIND_RECORD_FRAMER_MACROS_SVH
`define UNWIND_RECORD_FRAMER_MACROS_SVH

// same-cycle implication, disabled in reset
`define URF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define URF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/urf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urf_pkg
// Types and constants for the unwind record framer.
// ---------------------------------------------------------------------------
package urf_pkg;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  localparam logic [PADDR_W-1:0] REG_BASE_ADDR   = 4'h0;
  localparam logic [PADDR_W-1:0] REG_LENGTH_ADDR = 4'h8;

  localparam logic [32:0] HEADER_BYTES = 33'd8;
  localparam logic [31:0] WIDE_LENGTH  = 32'hFFFF_FFFF;
  localparam logic [31:0] MIN_LENGTH   = 32'd4;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_DESCRIPTOR = 3'd0,
    KIND_TERMINATOR = 3'd1,
    KIND_EXHAUSTED  = 3'd2,
    KIND_WIDE       = 3'd3,
    KIND_OVERRUN    = 3'd4,
    KIND_SHORT      = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    PH_LENGTH  = 2'd0,
    PH_ID      = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] addr;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } walk_out_t;

endpackage

>>> sv/urf_cfg_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urf_cfg_regs
// APB register file: section base address and section length.
// ---------------------------------------------------------------------------
module urf_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urf_pkg::PADDR_W-1:0] paddr,
  input  logic [urf_pkg::PDATA_W-1:0] pwdata,
  output logic [urf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [63:0]                 section_base,
  output logic [31:0]                 section_length
);
  import urf_pkg::*;

  logic [63:0] base_r;
  logic [31:0] length_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r   <= '0;
      length_r <= '0;
    end else if (wr_en) begin
      case (paddr)
        REG_BASE_ADDR:   base_r   <= pwdata;
        REG_LENGTH_ADDR: length_r <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      REG_BASE_ADDR:   prdata = base_r;
      REG_LENGTH_ADDR: prdata = {32'd0, length_r};
      default:         prdata = '0;
    endcase
  end

  assign section_base   = base_r;
  assign section_length = length_r;

endmodule

>>> sv/urf_walker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urf_walker
// Record walk state and the per-byte update; emits up to two results.
// ---------------------------------------------------------------------------
module urf_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic [63:0]         section_base,
  input  logic [31:0]         section_length,
  output urf_pkg::walk_out_t  walk_out
);
  import urf_pkg::*;

  logic [31:0] byte_offset_r, byte_offset_nxt;
  logic [31:0] record_start_r, record_start_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  biw_r, biw_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] remain_r, remain_nxt;
  logic        finished_r, finished_nxt;

  logic        first_byte;
  logic        word_done;
  logic [31:0] word_base;
  logic [31:0] word_new;
  logic [31:0] remain_dec;
  logic [33:0] record_end;
  logic        end_rec;
  logic        end_exh;
  logic [1:0]  n;
  kind_t       kind0, kind1;
  logic [31:0] off0, off1;

  function automatic logic room_at(input logic [31:0] start, input logic [31:0] len);
    return ({1'b0, start} + HEADER_BYTES) <= {1'b0, len};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r  <= '0;
      record_start_r <= '0;
      phase_r        <= PH_LENGTH;
      biw_r          <= '0;
      word_r         <= '0;
      remain_r       <= '0;
      finished_r     <= 1'b0;
    end else begin
      byte_offset_r  <= byte_offset_nxt;
      record_start_r <= record_start_nxt;
      phase_r        <= phase_nxt;
      biw_r          <= biw_nxt;
      word_r         <= word_nxt;
      remain_r       <= remain_nxt;
      finished_r     <= finished_nxt;
    end
  end

  always_comb begin
    byte_offset_nxt  = byte_offset_r;
    record_start_nxt = record_start_r;
    phase_nxt        = phase_r;
    biw_nxt          = biw_r;
    word_nxt         = word_r;
    remain_nxt       = remain_r;
    finished_nxt     = finished_r;

    first_byte = (phase_r == PH_LENGTH) && (biw_r == 2'd0);
    word_done  = (biw_r == 2'd3);
    word_base  = first_byte ? 32'd0 : word_r;
    word_new   = word_base | ({24'd0, in_byte} << {biw_r, 3'b000});
    remain_dec = (remain_r != 32'd0) ? (remain_r - 32'd1) : 32'd0;
    record_end = {2'b00, record_start_r} + 34'd4 + {2'b00, word_new};
    end_rec    = 1'b0;
    end_exh    = 1'b0;
    n          = 2'd0;
    kind0      = KIND_DESCRIPTOR;
    kind1      = KIND_EXHAUSTED;
    off0       = record_start_r;
    off1       = byte_offset_r + 32'd1;

    if (in_fire && !finished_r) begin
      if (first_byte && !room_at(record_start_r, section_length)) begin
        n            = 2'd1;
        kind0        = KIND_EXHAUSTED;
        finished_nxt = 1'b1;
      end else begin
        byte_offset_nxt = byte_offset_r + 32'd1;
        case (phase_r)
          PH_LENGTH: begin
            word_nxt = word_new;
            if (!word_done) begin
              biw_nxt = biw_r + 2'd1;
            end else begin
              biw_nxt = 2'd0;
              if (word_new == 32'd0) begin
                n = 2'd1; kind0 = KIND_TERMINATOR; finished_nxt = 1'b1;
              end else if (word_new == WIDE_LENGTH) begin
                n = 2'd1; kind0 = KIND_WIDE; finished_nxt = 1'b1;
              end else if (record_end > {2'b00, section_length}) begin
                n = 2'd1; kind0 = KIND_OVERRUN; finished_nxt = 1'b1;
              end else if (word_new < MIN_LENGTH) begin
                n = 2'd1; kind0 = KIND_SHORT; finished_nxt = 1'b1;
              end else begin
                remain_nxt = word_new;
                phase_nxt  = PH_ID;
                word_nxt   = 32'd0;
              end
            end
          end
          PH_ID: begin
            word_nxt   = word_new;
            remain_nxt = remain_dec;
            if (!word_done) begin
              biw_nxt = biw_r + 2'd1;
            end else begin
              biw_nxt = 2'd0;
              if (word_new != 32'd0) begin
                n = 2'd1; kind0 = KIND_DESCRIPTOR;
              end
              if (remain_dec == 32'd0) end_rec = 1'b1;
              else                     phase_nxt = PH_PAYLOAD;
            end
          end
          default: begin
            if (remain_r <= 32'd1) begin
              remain_nxt = 32'd0;
              end_rec    = 1'b1;
            end else begin
              remain_nxt = remain_r - 32'd1;
            end
          end
        endcase

        if (end_rec) begin
          record_start_nxt = byte_offset_nxt;
          phase_nxt        = PH_LENGTH;
          biw_nxt          = 2'd0;
          word_nxt         = 32'd0;
          end_exh          = !room_at(byte_offset_nxt, section_length);
        end
        if (end_exh) begin
          finished_nxt = 1'b1;
          if (n == 2'd0) begin
            n     = 2'd1;
            kind0 = KIND_EXHAUSTED;
            off0  = byte_offset_nxt;
          end else begin
            n = 2'd2;
          end
        end
      end
    end
  end

  always_comb begin
    walk_out.count     = n;
    walk_out.res0.kind = kind0;
    walk_out.res0.addr = section_base + {32'd0, off0};
    walk_out.res0.last = (n == 2'd1);
    walk_out.res1.kind = kind1;
    walk_out.res1.addr = section_base + {32'd0, off1};
    walk_out.res1.last = 1'b1;
  end

endmodule

>>> sv/urf_result_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urf_result_queue
// Small result queue: takes up to two results a cycle, hands out one.
// ---------------------------------------------------------------------------
module urf_result_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  urf_pkg::walk_out_t walk_out,
  input  logic               pop,
  output logic               head_valid,
  output urf_pkg::result_t   head,
  output logic               full_for_pair
);
  import urf_pkg::*;

  result_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]           n_push;
  logic                 do_pop;

  assign n_push = push ? walk_out.count : 2'd0;
  assign do_pop = pop & head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + Q_PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + Q_PTR_W'(do_pop);
    count_nxt  = count_r + Q_CNT_W'(n_push) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) q_r[wr_ptr_r] <= walk_out.res0;
    if (n_push == 2'd2) q_r[wr_ptr_r + Q_PTR_W'(1)] <= walk_out.res1;
  end

  assign head_valid    = (count_r != '0);
  assign head          = q_r[rd_ptr_r];
  assign full_for_pair = (count_r > Q_CNT_W'(Q_DEPTH - 2));

endmodule

>>> sv/unwind_record_framer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// unwind_record_framer
// Frames length/id records of an unwind section fed one byte per item.
// ---------------------------------------------------------------------------
// Takes one section byte per cycle while in_stall is low; the walk state
// updates in the cycle the byte is accepted, and its results (zero, one, or
// two per byte) enter a four-entry result queue that drains one result per
// cycle while out_stall is low. in_stall rises only while the queue holds
// more than two results, so with a free-running consumer the rate is one
// byte per clock. Program section_base (0x0) and section_length (0x8) before
// the first byte; after a terminator, error or exhaustion result, further
// bytes are accepted and dropped. No clearing pass is needed after reset.
module unwind_record_framer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_result_kind,
  output logic [63:0]                 out_record_address,
  output logic                        out_last_of_run,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urf_pkg::PADDR_W-1:0] paddr,
  input  logic [urf_pkg::PDATA_W-1:0] pwdata,
  output logic [urf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import urf_pkg::*;

  logic        in_fire;
  logic [63:0] section_base;
  logic [31:0] section_length;
  walk_out_t   walk_out;
  result_t     head;
  logic        full_for_pair;

  assign in_stall = full_for_pair;
  assign in_fire  = in_valid & ~in_stall;

  urf_cfg_regs u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .section_base   (section_base),
    .section_length (section_length)
  );

  urf_walker u_walker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_byte        (in_data_byte),
    .section_base   (section_base),
    .section_length (section_length),
    .walk_out       (walk_out)
  );

  urf_result_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (in_fire),
    .walk_out      (walk_out),
    .pop           (~out_stall),
    .head_valid    (out_valid),
    .head          (head),
    .full_for_pair (full_for_pair)
  );

  assign out_result_kind    = head.kind;
  assign out_record_address = head.addr;
  assign out_last_of_run    = head.last;

endmodule

>>> sv/urf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// urf_checker
// Port-level checks on the framer result channel.
// ---------------------------------------------------------------------------
`include "unwind_record_framer_macros.svh"

module urf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_result_kind,
  input logic [63:0] out_record_address,
  input logic        out_last_of_run
);
  import urf_pkg::*;

  `URF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped while stalled")
  `URF_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_record_address) && $stable(out_result_kind), "stalled result changed")
  `URF_ASSERT_IMPL(a_end_is_last, clk, rst_n, out_valid && (out_result_kind != KIND_DESCRIPTOR), out_last_of_run, "walk-ending result not last")
  `URF_ASSERT_IMPL(a_pair_head, clk, rst_n, out_valid && !out_last_of_run, out_result_kind == KIND_DESCRIPTOR, "first of a pair not a descriptor")
  `URF_ASSERT_IMPL(a_kind_range, clk, rst_n, out_valid, out_result_kind <= KIND_SHORT, "result kind out of range")

endmodule

bind unwind_record_framer urf_checker u_urf_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_result_kind    (out_result_kind),
  .out_record_address (out_record_address),
  .out_last_of_run    (out_last_of_run)
);
